>>> rtl/group_order_scatter_core_assert.svh
// Assertion macros shared by the checker of the group order scatter core.
`ifndef GROUP_ORDER_SCATTER_CORE_ASSERT_SVH
`define GROUP_ORDER_SCATTER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define GOS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define GOS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/gos_pkg.sv
// Package with widths, codes and defaults of the group order scatter core.
package gos_pkg;

	localparam int VALUE_W = 18;
	localparam int OFFSET_W = 17;
	localparam int SLOT_W = 16;
	localparam int INDEX_W = 16;

	localparam int DEF_MAX_GROUPS = 1024;
	localparam int DEF_MAX_ITEMS = 65536;

	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_KEY = 1'b1
	} func_t;

endpackage

>>> rtl/group_order_scatter_core.sv
// Group order scatter core: stable counting-sort slot assignment per key.
//
// The block takes one beat per cycle while input stall is low. A load beat stores the
// running total as the next group's start offset; a key beat reads its group's offset from
// a synchronous memory, sends out the slot and item index, and writes the incremented
// offset back when the read stage advances. A key that hits the entry written by
// the beat just ahead of it takes the new value from a forwarding register, so keys of
// one group stream at full rate. A result passes from the read stage into an output
// register and waits there; input stall rises only while that register is held by the
// output stall and the read stage is occupied. The offset memory is not
// cleared after reset; a key can only reach entries that a load of the same job wrote.
module group_order_scatter_core
	import gos_pkg::*;
#(
	parameter int MAX_GROUPS = DEF_MAX_GROUPS,
	parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      func,
	input  logic signed [VALUE_W-1:0] value,
	input  logic                      last,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [SLOT_W-1:0]         slot,
	output logic [INDEX_W-1:0]        item_index,
	output logic                      overflow
);

	localparam int GC_W = $clog2(MAX_GROUPS + 1);
	localparam int GA_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int CMP_W = (GC_W > OFFSET_W) ? GC_W : OFFSET_W;
	localparam int TOT_W = $clog2(longint'(MAX_ITEMS) + 1);
	localparam int WIDE_W = (TOT_W > OFFSET_W) ? TOT_W : OFFSET_W;
	localparam int SUM_W = WIDE_W + 1;

	logic [OFFSET_W-1:0] offset_mem_q [MAX_GROUPS];

	logic [TOT_W-1:0]   total_q;
	logic [GC_W-1:0]    groups_q;
	logic [INDEX_W-1:0] key_cnt_q;
	logic               ovf_q;

	logic                valid_s1;
	logic                we_s1;
	logic                key_s1;
	logic [GA_W-1:0]     addr_s1;
	logic [OFFSET_W-1:0] rd_data_s1;
	logic [OFFSET_W-1:0] load_data_s1;
	logic                fwd_s1;
	logic [OFFSET_W-1:0] fwd_data_s1;
	logic [INDEX_W-1:0]  index_s1;
	logic                ovf_s1;

	logic                out_valid_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [INDEX_W-1:0]  index_q;
	logic                ovf_out_q;

	logic                accept;
	logic                adv;
	logic                is_key;
	logic [CMP_W-1:0]    key_ext;
	logic                key_hit;
	logic [GA_W-1:0]     rd_addr;
	logic                load_ok;
	logic [OFFSET_W-1:0] size;
	logic [WIDE_W-1:0]   total_wide;
	logic [SUM_W-1:0]    sum;
	logic                sum_ovf;
	logic [OFFSET_W-1:0] cur_off;
	logic [OFFSET_W-1:0] inc_off;
	logic                wr_en;
	logic [OFFSET_W-1:0] wr_data;

	assign adv = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign accept = in_valid && !in_stall;

	assign is_key = (func == FUNC_KEY);
	assign key_ext = CMP_W'(value[OFFSET_W-1:0]);
	assign key_hit = !value[VALUE_W-1] && (key_ext < CMP_W'(groups_q));
	assign rd_addr = key_ext[GA_W-1:0];

	assign load_ok = (groups_q < GC_W'(MAX_GROUPS));
	assign size = value[VALUE_W-1] ? '0 : value[OFFSET_W-1:0];
	assign total_wide = WIDE_W'(total_q);
	assign sum = SUM_W'(total_q) + SUM_W'(size);
	assign sum_ovf = (sum > SUM_W'(MAX_ITEMS));

	assign cur_off = fwd_s1 ? fwd_data_s1 : rd_data_s1;
	assign inc_off = (cur_off == '1) ? cur_off : cur_off + 1'b1;
	assign wr_data = key_s1 ? inc_off : load_data_s1;
	assign wr_en = valid_s1 && adv && we_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			offset_mem_q[addr_s1] <= wr_data;
		end
		if (accept) begin
			rd_data_s1 <= offset_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			groups_q <= '0;
			key_cnt_q <= '0;
			ovf_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (accept && !is_key && load_ok) begin
				groups_q <= groups_q + 1'b1;
				if (sum_ovf) begin
					total_q <= TOT_W'(MAX_ITEMS);
					ovf_q <= 1'b1;
				end else begin
					total_q <= sum[TOT_W-1:0];
				end
			end
			if (accept && is_key) begin
				if (last) begin
					total_q <= '0;
					groups_q <= '0;
					key_cnt_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					key_cnt_q <= key_cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_s1 <= is_key;
			we_s1 <= is_key ? key_hit : load_ok;
			addr_s1 <= is_key ? rd_addr : groups_q[GA_W-1:0];
			load_data_s1 <= total_wide[OFFSET_W-1:0];
			fwd_s1 <= wr_en && (addr_s1 == rd_addr);
			fwd_data_s1 <= wr_data;
			index_s1 <= key_cnt_q;
			ovf_s1 <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && adv && key_s1 && we_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv && key_s1 && we_s1) begin
			slot_q <= cur_off[SLOT_W-1:0];
			index_q <= index_s1;
			ovf_out_q <= ovf_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign slot = slot_q;
	assign item_index = index_q;
	assign overflow = ovf_out_q;

endmodule

>>> rtl/gos_checker.sv
// Port-level checker for the group order scatter core, with its bind statement.
`include "group_order_scatter_core_assert.svh"

module gos_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] slot,
	input logic [15:0] item_index,
	input logic        overflow
);

	`GOS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped while stalled")
	`GOS_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(slot) && $stable(item_index) && $stable(overflow), "stalled result beat changed")
	`GOS_ASSERT_NOW(a_free_flow, !out_valid, !in_stall, "input stalled with an empty output register")
	`GOS_ASSERT_NEXT(a_one_deep, in_valid && !in_stall && out_valid && out_stall, !out_stall || in_stall, "second beat taken while the output stays blocked")

endmodule

bind group_order_scatter_core gos_checker u_gos_checker (.*);

>>> test/tb.sv
// Testbench for the group order scatter core: random grouping jobs checked against a slot model.
`timescale 1ns / 100ps

module tb;
	import gos_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int RANDOM_BEATS = 560;
	localparam int TAIL_KEYS = 20;

	typedef struct {
		func_t                      f;
		logic signed [VALUE_W-1:0]  v;
		logic                       lst;
		bit                         hold;
	} beat_t;

	typedef struct {
		logic [SLOT_W-1:0]  slot;
		logic [INDEX_W-1:0] idx;
		logic               ovf;
	} place_t;

	typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic                      func;
	logic signed [VALUE_W-1:0] value;
	logic                      last;
	logic                      out_valid;
	logic                      out_stall;
	logic [SLOT_W-1:0]         slot;
	logic [INDEX_W-1:0]        item_index;
	logic                      overflow;

	beat_t  beats_to_send[$];
	place_t due_places[$];

	logic [OFFSET_W-1:0] grp_start [DEF_MAX_GROUPS];
	int                  size_sum;
	int                  grp_count;
	logic [INDEX_W-1:0]  key_idx;
	logic                sum_ovf;

	int beats_built;
	int beats_in;
	int places_seen;
	int ovf_places;
	int jobs_built;
	int errors;
	int idle_cycles;
	bit in_took;

	group_order_scatter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.value     (value),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.slot      (slot),
		.item_index(item_index),
		.overflow  (overflow)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void clear_job_state();
		size_sum = 0;
		grp_count = 0;
		key_idx = '0;
		sum_ovf = 1'b0;
	endfunction

	function automatic void place_beat(input func_t f, input logic signed [VALUE_W-1:0] v,
			input logic lst);
		int sz;
		int g;
		logic [OFFSET_W-1:0] off;
		place_t p;
		if (f == FUNC_LOAD) begin
			sz = (v < 0) ? 0 : int'(v);
			if (grp_count < DEF_MAX_GROUPS) begin
				grp_start[grp_count] = size_sum[OFFSET_W-1:0];
				grp_count++;
				if (size_sum + sz > DEF_MAX_ITEMS) begin
					sum_ovf = 1'b1;
					size_sum = DEF_MAX_ITEMS;
				end else begin
					size_sum = size_sum + sz;
				end
			end
			return;
		end
		if (v >= 0 && int'(v) < grp_count) begin
			g = int'(v);
			off = grp_start[g];
			p.slot = off[SLOT_W-1:0];
			p.idx = key_idx;
			p.ovf = sum_ovf;
			due_places.push_back(p);
			if (off != '1)
				grp_start[g] = off + 1'b1;
		end
		key_idx = key_idx + 1'b1;
		if (lst)
			clear_job_state();
	endfunction

	task automatic push_beat(input func_t f, input int v, input logic lst, input bit hold = 1'b0);
		beat_t b;
		b.f = f;
		b.v = v[VALUE_W-1:0];
		b.lst = lst;
		b.hold = hold;
		beats_to_send.push_back(b);
		beats_built++;
	endtask

	task automatic build_job(input bit hold);
		int ng;
		int nk;
		int r;
		int k;
		jobs_built++;
		ng = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
		nk = $urandom_range(1, 24);
		for (int i = 0; i < ng; i++) begin
			if ($urandom_range(0, 19) == 0)
				k = $urandom_range(20000, 65536);
			else if ($urandom_range(0, 19) == 0)
				k = -int'($urandom_range(1, 131072));
			else
				k = $urandom_range(0, 5);
			push_beat(FUNC_LOAD, k, $urandom_range(0, 5) == 0, hold && i == 0);
		end
		for (int i = 0; i < nk; i++) begin
			r = $urandom_range(0, 9);
			if (r < 8)
				k = $urandom_range(0, ng - 1);
			else if (r == 8)
				k = -1;
			else
				k = ng + $urandom_range(0, 3);
			push_beat(FUNC_KEY, k, i == nk - 1 && $urandom_range(0, 9) != 0);
		end
	endtask

	task automatic build_noise();
		int n;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++)
			push_beat($urandom_range(0, 1) ? FUNC_KEY : FUNC_LOAD,
				int'($urandom_range(0, 262143)) - 131072, $urandom_range(0, 1));
	endtask

	task automatic build_stimulus();
		int start;
		// Mixed sizes, including a negative one, a last mark on a load and a saturating total.
		push_beat(FUNC_LOAD, 0, 1'b0);
		push_beat(FUNC_LOAD, -131072, 1'b0);
		push_beat(FUNC_LOAD, 3, 1'b0);
		push_beat(FUNC_LOAD, 2, 1'b1);
		push_beat(FUNC_LOAD, 65536, 1'b0);
		push_beat(FUNC_KEY, -1, 1'b0);
		push_beat(FUNC_KEY, 2, 1'b0);
		push_beat(FUNC_KEY, 3, 1'b0);
		push_beat(FUNC_KEY, 2, 1'b0);
		push_beat(FUNC_KEY, 0, 1'b0);
		push_beat(FUNC_KEY, 4, 1'b0);
		push_beat(FUNC_KEY, 5, 1'b0);
		push_beat(FUNC_KEY, 131071, 1'b0);
		push_beat(FUNC_KEY, -131072, 1'b0);
		push_beat(FUNC_KEY, 2, 1'b1);
		// A fresh job after a full drain; the empty group gets more keys than its size.
		push_beat(FUNC_LOAD, 7, 1'b0, 1'b1);
		push_beat(FUNC_LOAD, 0, 1'b0);
		push_beat(FUNC_KEY, 1, 1'b0);
		push_beat(FUNC_KEY, 0, 1'b0);
		push_beat(FUNC_KEY, 0, 1'b1);
		push_beat(FUNC_KEY, -1, 1'b1);
		jobs_built += 3;

		// More loads than the offset store holds.
		for (int i = 0; i < DEF_MAX_GROUPS + 6; i++)
			push_beat(FUNC_LOAD, $urandom_range(0, 60), 1'b0);
		for (int i = 0; i < 40; i++)
			push_beat(FUNC_KEY, (i % 2) ? $urandom_range(1000, 1030) : $urandom_range(0, 20),
				i == 39);
		jobs_built++;

		start = beats_built;
		while (beats_built - start < RANDOM_BEATS) begin
			if ($urandom_range(0, 6) == 0)
				build_noise();
			else
				build_job($urandom_range(0, 9) == 0);
		end

		// A saturated total feeds a run of keys that all carry the overflow mark.
		push_beat(FUNC_LOAD, 65536, 1'b0, 1'b1);
		push_beat(FUNC_LOAD, 5, 1'b0);
		for (int i = 0; i < TAIL_KEYS; i++)
			push_beat(FUNC_KEY, 1, i == TAIL_KEYS - 1);
		jobs_built++;
		build_job(1'b0);
		push_beat(FUNC_KEY, 0, 1'b1);
	endtask

	always @(negedge clk) begin : drive
		beat_t b;
		logic nxt_valid;
		int burst_left;
		int gap_left;
		if (arst_n) begin
			nxt_valid = in_valid && !in_took;
			in_took = 1'b0;
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (beats_to_send.size() > 0 &&
						!(beats_to_send[0].hold && due_places.size() != 0)) begin
					b = beats_to_send.pop_front();
					func <= b.f;
					value <= b.v;
					last <= b.lst;
					nxt_valid = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 60);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
					end
				end
			end
			in_valid <= nxt_valid;
		end
	end

	always @(negedge clk) begin : receive
		rx_mode_t mode;
		int mode_left;
		int hold_left;
		bit hold1_done;
		bit hold2_done;
		if (arst_n) begin
			if (!hold1_done && places_seen >= 60) begin
				hold_left = 400;
				hold1_done = 1'b1;
			end
			if (!hold2_done && places_seen >= 200) begin
				hold_left = 400;
				hold2_done = 1'b1;
			end
			if (mode_left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 300);
			end else begin
				mode_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (mode)
					RX_FREE: out_stall <= 1'b0;
					RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ~out_stall;
				endcase
			end
		end
	end

	always @(posedge clk) begin : watch
		place_t e;
		if (arst_n) begin
			idle_cycles++;
			if (in_valid && !in_stall) begin
				in_took = 1'b1;
				beats_in++;
				idle_cycles = 0;
				place_beat(func_t'(func), value, last);
			end
			if (out_valid && !out_stall) begin
				idle_cycles = 0;
				places_seen++;
				if (due_places.size() == 0) begin
					errors++;
					$error("result with no expectation: slot %0d item_index %0d overflow %0b",
						slot, item_index, overflow);
				end else begin
					e = due_places.pop_front();
					if (e.ovf)
						ovf_places++;
					if (slot !== e.slot) begin
						errors++;
						$error("slot: expected %0d, got %0d", e.slot, slot);
					end
					if (item_index !== e.idx) begin
						errors++;
						$error("item_index: expected %0d, got %0d", e.idx, item_index);
					end
					if (overflow !== e.ovf) begin
						errors++;
						$error("overflow: expected %0b, got %0b", e.ovf, overflow);
					end
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = 1'b0;
		value = '0;
		last = 1'b0;
		out_stall = 1'b0;
		clear_job_state();
		build_stimulus();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		while (beats_in != beats_built || due_places.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
		$display("Sent %0d beats in %0d jobs plus noise; checked %0d slots, %0d with overflow set.",
			beats_in, jobs_built, places_seen, ovf_places);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
